/* rtl/mms_pkg.sv */
`timescale 1ns / 1ps

package mms_pkg;

    typedef enum logic [3:0] {
        SEQ_IDLE      = 4'd0,
        SEQ_SEND_A    = 4'd1,
        SEQ_WAIT_A    = 4'd2,
        SEQ_SEND_B    = 4'd3,
        SEQ_WAIT_B    = 4'd4,
        SEQ_SEND_MODE = 4'd5,
        SEQ_WAIT_MODE = 4'd6,
        SEQ_SEND_READ = 4'd7,
        SEQ_WAIT_READ = 4'd8
    } seq_state_e;

    // sensor register addresses
    localparam logic [1:0] REG_SETUP_A = 2'd0;
    localparam logic [1:0] REG_SETUP_B = 2'd1;
    localparam logic [1:0] REG_MODE    = 2'd2;
    localparam logic [1:0] REG_DATA    = 2'd3;
    localparam logic [7:0] MODE_SINGLE = 8'h02;

    // op_status codes
    localparam logic [1:0] ST_PROCESSING = 2'd0;
    localparam logic [1:0] ST_OK         = 2'd1;
    localparam logic [1:0] ST_ERROR      = 2'd2;

    // bus_status codes
    localparam logic [1:0] BUS_OK         = 2'd0;
    localparam logic [1:0] BUS_PROCESSING = 2'd1;

    // action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETUP_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETUP_B = 2'd1;

    typedef struct packed {
        logic        action;
        logic        request_accepted;
        logic [1:0]  bus_status;
        logic [47:0] read_bytes;
    } in_item_t;

    typedef struct packed {
        logic        command_issued;
        logic        command_is_read;
        logic [1:0]  register_address;
        logic [7:0]  write_byte;
        logic [1:0]  op_status;
        logic        config_error;
        logic [15:0] x_value;
        logic [15:0] z_value;
        logic [15:0] y_value;
    } out_item_t;

    typedef struct packed {
        logic                   en;
        logic [CFG_INDEX_W-1:0] index;
        logic [7:0]             data;
    } cfg_wr_t;

endpackage

/* rtl/mms_seq.sv */
`timescale 1ns / 1ps

module mms_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  mms_pkg::in_item_t   in_item,
    input  mms_pkg::cfg_wr_t    cfg_wr,
    output mms_pkg::out_item_t  result
);

    mms_pkg::seq_state_e state_reg, state_next;
    logic [7:0]  setup_a_reg, setup_a_next;
    logic [7:0]  setup_b_reg, setup_b_next;
    logic [1:0]  req_reg, req_next;
    logic [1:0]  written_reg, written_next;
    logic [1:0]  status_reg, status_next;
    logic        cfg_err_reg, cfg_err_next;
    logic [47:0] meas_reg, meas_next;

    logic        issued;
    logic        is_read;
    logic [1:0]  addr;
    logic [7:0]  wbyte;
    logic        waiting;

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        written_next = written_reg;
        status_next  = status_reg;
        cfg_err_next = cfg_err_reg;
        meas_next    = meas_reg;
        setup_a_next = setup_a_reg;
        setup_b_next = setup_b_reg;
        issued       = 1'b0;
        is_read      = 1'b0;
        addr         = 2'd0;
        wbyte        = 8'd0;
        waiting      = 1'b0;

        if (step_en) begin
            if (in_item.action == mms_pkg::ACT_START) begin
                if (req_reg == 2'b11) begin
                    // setup writes that already landed are skipped
                    if (!written_reg[0]) begin
                        state_next = mms_pkg::SEQ_SEND_A;
                    end else if (!written_reg[1]) begin
                        state_next = mms_pkg::SEQ_SEND_B;
                    end else begin
                        state_next = mms_pkg::SEQ_SEND_MODE;
                    end
                    cfg_err_next = 1'b0;
                end else begin
                    state_next   = mms_pkg::SEQ_IDLE;
                    cfg_err_next = 1'b1;
                end
                status_next = mms_pkg::ST_PROCESSING;
            end else begin
                case (state_reg)
                    mms_pkg::SEQ_SEND_A: begin
                        issued = 1'b1;
                        addr   = mms_pkg::REG_SETUP_A;
                        wbyte  = setup_a_reg;
                        if (in_item.request_accepted) state_next = mms_pkg::SEQ_WAIT_A;
                    end
                    mms_pkg::SEQ_WAIT_A: begin
                        waiting = 1'b1;
                        if (in_item.bus_status == mms_pkg::BUS_OK) begin
                            written_next[0] = 1'b1;
                            state_next      = mms_pkg::SEQ_SEND_B;
                        end
                    end
                    mms_pkg::SEQ_SEND_B: begin
                        issued = 1'b1;
                        addr   = mms_pkg::REG_SETUP_B;
                        wbyte  = setup_b_reg;
                        if (in_item.request_accepted) state_next = mms_pkg::SEQ_WAIT_B;
                    end
                    mms_pkg::SEQ_WAIT_B: begin
                        waiting = 1'b1;
                        if (in_item.bus_status == mms_pkg::BUS_OK) begin
                            written_next[1] = 1'b1;
                            state_next      = mms_pkg::SEQ_SEND_MODE;
                        end
                    end
                    mms_pkg::SEQ_SEND_MODE: begin
                        issued = 1'b1;
                        addr   = mms_pkg::REG_MODE;
                        wbyte  = mms_pkg::MODE_SINGLE;
                        if (in_item.request_accepted) state_next = mms_pkg::SEQ_WAIT_MODE;
                    end
                    mms_pkg::SEQ_WAIT_MODE: begin
                        waiting = 1'b1;
                        if (in_item.bus_status == mms_pkg::BUS_OK) begin
                            state_next = mms_pkg::SEQ_SEND_READ;
                        end
                    end
                    mms_pkg::SEQ_SEND_READ: begin
                        issued  = 1'b1;
                        is_read = 1'b1;
                        addr    = mms_pkg::REG_DATA;
                        if (in_item.request_accepted) state_next = mms_pkg::SEQ_WAIT_READ;
                    end
                    mms_pkg::SEQ_WAIT_READ: begin
                        waiting = 1'b1;
                        if (in_item.bus_status == mms_pkg::BUS_OK) begin
                            meas_next   = in_item.read_bytes;
                            state_next  = mms_pkg::SEQ_IDLE;
                            status_next = mms_pkg::ST_OK;
                        end
                    end
                    default: begin
                        state_next = mms_pkg::SEQ_IDLE;
                    end
                endcase
                // error, or the unused code 3, aborts a wait
                if (waiting && in_item.bus_status != mms_pkg::BUS_OK
                        && in_item.bus_status != mms_pkg::BUS_PROCESSING) begin
                    status_next = mms_pkg::ST_ERROR;
                    state_next  = mms_pkg::SEQ_IDLE;
                end
            end
        end

        if (cfg_wr.en) begin
            case (cfg_wr.index)
                mms_pkg::CFG_SETUP_A: begin
                    setup_a_next    = cfg_wr.data;
                    req_next[0]     = 1'b1;
                    written_next[0] = 1'b0;
                end
                mms_pkg::CFG_SETUP_B: begin
                    setup_b_next    = cfg_wr.data;
                    req_next[1]     = 1'b1;
                    written_next[1] = 1'b0;
                end
                default: begin
                end
            endcase
        end

        result.command_issued   = issued;
        result.command_is_read  = is_read;
        result.register_address = addr;
        result.write_byte       = wbyte;
        result.op_status        = status_next;
        result.config_error     = cfg_err_next;
        result.x_value          = meas_next[47:32];
        result.z_value          = meas_next[31:16];
        result.y_value          = meas_next[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mms_pkg::SEQ_IDLE;
            setup_a_reg <= 8'd0;
            setup_b_reg <= 8'd0;
            req_reg     <= 2'b00;
            written_reg <= 2'b00;
            status_reg  <= mms_pkg::ST_PROCESSING;
            cfg_err_reg <= 1'b0;
            meas_reg    <= 48'd0;
        end else begin
            state_reg   <= state_next;
            setup_a_reg <= setup_a_next;
            setup_b_reg <= setup_b_next;
            req_reg     <= req_next;
            written_reg <= written_next;
            status_reg  <= status_next;
            cfg_err_reg <= cfg_err_next;
            meas_reg    <= meas_next;
        end
    end

    // a setup byte only counts as written once it has been requested
    assert property (@(posedge aclk) disable iff (!aresetn)
        (written_reg & ~req_reg) == 2'b00)
        else $error("written flag set without request");

    // a refused start leaves the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && in_item.action == mms_pkg::ACT_START && req_reg != 2'b11
        |=> state_reg == mms_pkg::SEQ_IDLE)
        else $error("refused start did not idle the sequencer");

    // captured data only changes when a read completes
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(step_en && state_reg == mms_pkg::SEQ_WAIT_READ) |=> $stable(meas_reg))
        else $error("measurement changed outside a read completion");

endmodule

/* rtl/magnetometer_measure_sequencer_core.sv */
`timescale 1ns / 1ps

// Single-measurement sequencer for a three-axis magnetometer on a two-wire bus.
// Input channel (s_*): one request per step, either a start or a polling tick
// carrying the bus master's accept flag, bus status and six read bytes.
// Result channel (m_*): exactly one result per request: the bus command to
// issue this tick, the measurement status, the config error flag and the last
// captured X, Z and Y values.
// Config channel (cfg_*): index 0 writes setup byte A, index 1 setup byte B;
// other indexes are ignored. cfg_ready is always high. Write only while idle.
// Latency: the result of a request is valid the cycle after it is accepted.
// Throughput: one request per cycle while m_ready is high; the state update and the output register
// both complete in the accepting cycle, so requests stream back to back.
// If the receiver stalls, the result is held in the output register and
// s_ready drops until it is taken; s_ready is high whenever the output
// register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous) idles the sequencer, clears the setup
// bytes, the requested and written flags, the status and the captured data,
// and empties the output register.

module magnetometer_measure_sequencer_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  mms_pkg::in_item_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output mms_pkg::out_item_t                    m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mms_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [7:0]                            cfg_data
);

    logic               m_valid_reg, m_valid_next;
    mms_pkg::out_item_t m_data_reg, m_data_next;
    mms_pkg::out_item_t step_result;
    mms_pkg::cfg_wr_t   cfg_wr;
    logic               s_fire;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.en    = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    mms_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (s_fire),
        .in_item (s_data),
        .cfg_wr  (cfg_wr),
        .result  (step_result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = step_result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted request produced no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.command_issued |->
        !m_data.command_is_read && m_data.register_address == mms_pkg::REG_SETUP_A
        && m_data.write_byte == 8'd0)
        else $error("command fields set without a command");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.command_is_read |->
        m_data.register_address == mms_pkg::REG_DATA && m_data.write_byte == 8'd0)
        else $error("read command with bad address or data byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.config_error |-> m_data.op_status == mms_pkg::ST_PROCESSING)
        else $error("config error with non-processing status");

endmodule
